### src/kji_pkg.sv
package kji_pkg;

  localparam int unsigned TimeW   = 24;
  localparam int unsigned PosW    = 32;
  localparam int unsigned FcW     = 9;
  localparam int unsigned JcW     = 6;
  localparam int unsigned FidxW   = 8;
  localparam int unsigned JidxW   = 5;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned CfgDatW = 16;

  // Quotient of the rounded division never exceeds 2^33, so 34 steps suffice.
  localparam int unsigned DivSteps = 34;
  localparam int unsigned DivCntW  = 6;
  localparam int unsigned ProdW    = 57;
  localparam int unsigned NumerW   = 58;
  localparam int unsigned RemW     = 25;

  typedef enum logic [1:0] {
    REQ_LOAD  = 2'd0,
    REQ_START = 2'd1,
    REQ_TICK  = 2'd2
  } req_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_COUNT = 8'd0,
    CFG_JOINT_COUNT = 8'd1
  } cfg_idx_e;

  typedef struct packed {
    logic accept;
    logic trd_last;
    logic trd_scan;
    logic chk_last;
    logic scan_step;
    logic cap_t1;
    logic cap_t0;
    logic prd1;
    logic cap_v0;
    logic cap_v1;
    logic mul;
    logic div_init;
    logic div_step;
    logic load_direct;
    logic load_quot;
    logic next_joint;
  } cmd_t;

  typedef struct packed {
    logic tick_go;
    logic final_hit;
    logic scan_more;
    logic direct;
    logic div_last;
    logic last_joint;
  } sts_t;

endpackage

### src/kji_if.sv
interface kji_req_if;
  import kji_pkg::*;
  logic                valid;
  logic                ready;
  logic [1:0]          req_type;
  logic [FidxW-1:0]    frame_index;
  logic [JidxW-1:0]    joint_index;
  logic [TimeW-1:0]    time_ms;
  logic signed [PosW-1:0] position;
  modport source (output valid, req_type, frame_index, joint_index, time_ms, position,
                  input ready);
  modport sink (input valid, req_type, frame_index, joint_index, time_ms, position,
                output ready);
endinterface

interface kji_res_if;
  import kji_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [JidxW-1:0]       out_joint;
  logic signed [PosW-1:0] out_position;
  logic                   last;
  modport source (output valid, out_joint, out_position, last, input ready);
  modport sink (input valid, out_joint, out_position, last, output ready);
endinterface

interface kji_cfg_if;
  import kji_pkg::*;
  logic               valid;
  logic               ready;
  logic [CfgIdxW-1:0] index;
  logic [CfgDatW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### src/kji_ram.sv
module kji_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                     wdata_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                     rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

### src/kji_ctrl.sv
module kji_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  kji_pkg::sts_t sts_i,
  output kji_pkg::cmd_t cmd_o
);
  import kji_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_LAST, S_CHK, S_SCAN, S_SCMP, S_T0, S_T0W, S_RD0, S_RD1, S_CAP,
    S_MUL, S_DINIT, S_DIV, S_FIN, S_EMIT
  } state_e;

  state_e state_q;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      S_IDLE:  cmd_o.accept = in_valid_i;
      S_LAST:  cmd_o.trd_last = 1'b1;
      S_CHK:   cmd_o.chk_last = 1'b1;
      S_SCAN:  cmd_o.trd_scan = 1'b1;
      S_SCMP: begin
        cmd_o.scan_step = sts_i.scan_more;
        cmd_o.cap_t1    = !sts_i.scan_more;
      end
      S_T0:    ;
      S_T0W:   cmd_o.cap_t0 = 1'b1;
      S_RD0:   ;
      S_RD1: begin
        cmd_o.cap_v0 = 1'b1;
        cmd_o.prd1   = 1'b1;
      end
      S_CAP:   cmd_o.cap_v1 = 1'b1;
      S_MUL: begin
        cmd_o.load_direct = sts_i.direct;
        cmd_o.mul         = !sts_i.direct;
      end
      S_DINIT: cmd_o.div_init = 1'b1;
      S_DIV:   cmd_o.div_step = 1'b1;
      S_FIN:   cmd_o.load_quot = 1'b1;
      S_EMIT:  cmd_o.next_joint = out_ready_i && !sts_i.last_joint;
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_o <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE:  if (in_valid_i && sts_i.tick_go) state_q <= S_LAST;
        S_LAST:  state_q <= S_CHK;
        S_CHK:   state_q <= sts_i.final_hit ? S_RD0 : S_SCAN;
        S_SCAN:  state_q <= S_SCMP;
        S_SCMP:  state_q <= sts_i.scan_more ? S_SCAN : S_T0;
        S_T0:    state_q <= S_T0W;
        S_T0W:   state_q <= S_RD0;
        S_RD0:   state_q <= S_RD1;
        S_RD1:   state_q <= S_CAP;
        S_CAP:   state_q <= S_MUL;
        S_MUL: begin
          if (sts_i.direct) begin
            state_q     <= S_EMIT;
            out_valid_o <= 1'b1;
          end else begin
            state_q <= S_DINIT;
          end
        end
        S_DINIT: state_q <= S_DIV;
        S_DIV:   if (sts_i.div_last) state_q <= S_FIN;
        S_FIN: begin
          state_q     <= S_EMIT;
          out_valid_o <= 1'b1;
        end
        S_EMIT: begin
          if (out_ready_i) begin
            out_valid_o <= 1'b0;
            state_q     <= sts_i.last_joint ? S_IDLE : S_RD0;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

### src/kji_dp.sv
module kji_dp #(
  parameter int unsigned MaxFrames = 256,
  parameter int unsigned MaxJoints = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [1:0]                     req_type_i,
  input  logic [kji_pkg::FidxW-1:0]      frame_index_i,
  input  logic [kji_pkg::JidxW-1:0]      joint_index_i,
  input  logic [kji_pkg::TimeW-1:0]      time_ms_i,
  input  logic signed [kji_pkg::PosW-1:0] position_i,
  input  logic                           cfg_we_i,
  input  logic [kji_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [kji_pkg::CfgDatW-1:0]    cfg_data_i,
  input  kji_pkg::cmd_t                  cmd_i,
  output kji_pkg::sts_t                  sts_o,
  output logic [kji_pkg::JidxW-1:0]      out_joint_o,
  output logic signed [kji_pkg::PosW-1:0] out_position_o,
  output logic                           out_last_o
);
  import kji_pkg::*;

  localparam int unsigned FW  = (MaxFrames > 1) ? $clog2(MaxFrames) : 1;
  localparam int unsigned JW  = (MaxJoints > 1) ? $clog2(MaxJoints) : 1;
  localparam int unsigned NW  = $clog2(MaxFrames + 1);
  localparam int unsigned JCW = $clog2(MaxJoints + 1);
  localparam int unsigned PosDepth = MaxFrames << JW;

  logic [FcW-1:0] fc_q;
  logic [JcW-1:0] jc_q;
  logic           playing_q;
  logic [TimeW-1:0] start_q, elapsed_q, t0_q, t1_q;
  logic           final_q;
  logic [FW-1:0]  i_q;
  logic [JW-1:0]  j_q;
  logic signed [PosW-1:0] v0_q, v1_q;
  logic [ProdW-1:0] prod_q;
  logic           neg_q;
  logic [RemW-1:0] rem_q;
  logic [DivSteps-1:0] quo_q;
  logic [DivCntW-1:0] cnt_q;

  logic [NW-1:0]  n;
  logic [JCW-1:0] jc;
  logic [FW-1:0]  n_m1, i_p1;
  logic [TimeW-1:0] t_rd;
  logic [PosW-1:0]  p_rd;
  logic [FW-1:0]  t_raddr, p_frame;
  logic [FW+JW-1:0] p_raddr, p_waddr;
  logic [31:0]    fidx_ext, jidx_ext;
  logic           load_ok, t_we, p_we;
  logic signed [PosW:0] diff;
  logic [PosW:0]  mag;
  logic [TimeW-1:0] num, den;
  logic [NumerW-1:0] numer;
  logic [RemW:0]  rem_sh;
  logic [RemW-1:0] den2;
  logic           q_bit;
  logic signed [DivSteps+1:0] lerp;

  assign n    = (32'(fc_q) > MaxFrames) ? NW'(MaxFrames) : NW'(fc_q);
  assign jc   = (32'(jc_q) > MaxJoints) ? JCW'(MaxJoints) : JCW'(jc_q);
  assign n_m1 = FW'(32'(n) - 32'd1);
  assign i_p1 = i_q + FW'(1);

  assign fidx_ext = 32'(frame_index_i);
  assign jidx_ext = 32'(joint_index_i);
  assign load_ok  = cmd_i.accept && (req_type_i == REQ_LOAD) && (fidx_ext < MaxFrames);
  assign t_we     = load_ok;
  assign p_we     = load_ok && (jidx_ext < MaxJoints);
  assign p_waddr  = {fidx_ext[FW-1:0], jidx_ext[JW-1:0]};

  assign t_raddr = cmd_i.trd_last ? n_m1 : (cmd_i.trd_scan ? i_p1 : i_q);
  assign p_frame = cmd_i.prd1 ? i_p1 : (final_q ? n_m1 : i_q);
  assign p_raddr = {p_frame, j_q};

  kji_ram #(.Width(TimeW), .Depth(MaxFrames)) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (fidx_ext[FW-1:0]),
    .wdata_i (time_ms_i),
    .raddr_i (t_raddr),
    .rdata_o (t_rd)
  );

  kji_ram #(.Width(PosW), .Depth(PosDepth)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (position_i),
    .raddr_i (p_raddr),
    .rdata_o (p_rd)
  );

  assign diff   = 33'(v1_q) - 33'(v0_q);
  assign mag    = diff[PosW] ? (~diff + 33'd1) : diff;
  assign num    = elapsed_q - t0_q;
  assign den    = t1_q - t0_q;
  assign den2   = {den, 1'b0};
  assign numer  = {prod_q, 1'b0} + NumerW'(den);
  assign rem_sh = {rem_q, quo_q[DivSteps-1]};
  assign q_bit  = (rem_sh >= {1'b0, den2});
  assign lerp   = neg_q ? (36'(v0_q) - 36'({2'b00, quo_q}))
                        : (36'(v0_q) + 36'({2'b00, quo_q}));

  always_comb begin
    sts_o.tick_go    = (req_type_i == REQ_TICK) && playing_q && (32'(n) >= 32'd2)
                       && (jc != '0);
    sts_o.final_hit  = (elapsed_q >= t_rd);
    sts_o.scan_more  = (elapsed_q > t_rd) && ((32'(i_q) + 32'd2) < 32'(n));
    sts_o.direct     = final_q || (elapsed_q < t0_q) || (t1_q == t0_q);
    sts_o.div_last   = (cnt_q == DivCntW'(DivSteps - 1));
    sts_o.last_joint = ((32'(j_q) + 32'd1) == 32'(jc));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fc_q      <= '0;
      jc_q      <= JcW'(1);
      playing_q <= 1'b0;
      start_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_FRAME_COUNT: fc_q <= cfg_data_i[FcW-1:0];
          CFG_JOINT_COUNT: jc_q <= cfg_data_i[JcW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.accept && (req_type_i == REQ_START) && (fc_q != '0)) begin
        playing_q <= 1'b1;
        start_q   <= time_ms_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) elapsed_q <= time_ms_i - start_q;
    if (cmd_i.chk_last) begin
      final_q <= (elapsed_q >= t_rd);
      i_q     <= '0;
      j_q     <= '0;
    end
    if (cmd_i.scan_step) i_q <= i_p1;
    if (cmd_i.cap_t1) t1_q <= t_rd;
    if (cmd_i.cap_t0) t0_q <= t_rd;
    if (cmd_i.cap_v0) v0_q <= p_rd;
    if (cmd_i.cap_v1) v1_q <= p_rd;
    if (cmd_i.mul) begin
      prod_q <= ProdW'(mag) * ProdW'(num);
      neg_q  <= diff[PosW];
    end
    if (cmd_i.div_init) begin
      rem_q <= RemW'(numer[NumerW-1:DivSteps]);
      quo_q <= numer[DivSteps-1:0];
      cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= q_bit ? RemW'(rem_sh - {1'b0, den2}) : rem_sh[RemW-1:0];
      quo_q <= {quo_q[DivSteps-2:0], q_bit};
      cnt_q <= cnt_q + DivCntW'(1);
    end
    if (cmd_i.load_direct || cmd_i.load_quot) begin
      out_joint_o <= JidxW'(32'(j_q));
      out_last_o  <= sts_o.last_joint;
    end
    if (cmd_i.load_direct) begin
      out_position_o <= (!final_q && (elapsed_q >= t0_q) && (t1_q == t0_q)) ? v1_q : v0_q;
    end
    if (cmd_i.load_quot) out_position_o <= lerp[PosW-1:0];
    if (cmd_i.next_joint) j_q <= j_q + JW'(1);
  end
endmodule

### src/keyframe_joint_interpolator_unit.sv
// Keyframe playback with linear interpolation. Load transactions write a keyframe time and
// one joint position; a start transaction records the playback origin; a tick transaction
// produces joint_count result transactions in joint order, the final one marked with last,
// once playback has started with at least two frames. Requests are taken one at a time; a
// tick holds off further requests until its final result is taken. Tick duration grows with
// the number of segments searched, one keyframe time read per step, with the joint count,
// with the bit-serial divider that rounds each joint's interpolation quotient and with
// output back-pressure. Joints that need no division (before the segment, zero-length
// segment) skip the divider, and a tick past the final keyframe skips the search.
// Configuration writes are accepted in every cycle but are meant for an idle block.
module keyframe_joint_interpolator_unit #(
  parameter int unsigned MAX_FRAMES = 256,
  parameter int unsigned MAX_JOINTS = 32
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  kji_req_if.sink   req_i,
  kji_res_if.source res_o,
  kji_cfg_if.sink   cfg_i
);
  import kji_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_i.ready = 1'b1;

  kji_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  kji_dp #(.MaxFrames(MAX_FRAMES), .MaxJoints(MAX_JOINTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_type_i     (req_i.req_type),
    .frame_index_i  (req_i.frame_index),
    .joint_index_i  (req_i.joint_index),
    .time_ms_i      (req_i.time_ms),
    .position_i     (req_i.position),
    .cfg_we_i       (cfg_i.valid),
    .cfg_index_i    (cfg_i.index),
    .cfg_data_i     (cfg_i.data),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_joint_o    (res_o.out_joint),
    .out_position_o (res_o.out_position),
    .out_last_o     (res_o.last)
  );
endmodule

### sim/kji_checker.sv
`timescale 1ns / 1ps

module kji_checker
  import kji_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  kji_req_if          req,
  kji_res_if          res,
  kji_cfg_if          cfg,
  output int unsigned err_count_o,
  output int unsigned pending_o,
  output int unsigned joints_seen_o
);

  typedef struct {
    logic [JidxW-1:0] joint;
    logic [PosW-1:0]  pos;
    logic             last;
  } joint_pos_t;

  joint_pos_t        joint_pos_q[$];
  logic [TimeW-1:0]  key_time[256];
  logic [PosW-1:0]   key_pos[256][32];
  logic              playing;
  logic [TimeW-1:0]  origin_ms;
  int unsigned       frames_cfg;
  int unsigned       joints_cfg;

  function automatic logic [PosW-1:0] blend(logic [PosW-1:0] a, logic [PosW-1:0] b,
                                            longint unsigned num, longint unsigned den);
    longint          v0;
    longint          diff;
    longint unsigned mag;
    longint unsigned q;
    v0   = longint'($signed(a));
    diff = longint'($signed(b)) - v0;
    mag  = longint'(diff < 0 ? -diff : diff) * num;
    q    = (2 * mag + den) / (2 * den);
    return (diff < 0) ? PosW'(v0 - longint'(q)) : PosW'(v0 + longint'(q));
  endfunction

  task automatic predict_tick(logic [TimeW-1:0] now_ms);
    int unsigned      n;
    int unsigned      jc;
    int unsigned      i;
    logic [TimeW-1:0] el;
    logic [TimeW-1:0] t0;
    logic [TimeW-1:0] t1;
    logic             fin;
    joint_pos_t       r;
    n  = (frames_cfg > 256) ? 256 : frames_cfg;
    jc = (joints_cfg > 32) ? 32 : joints_cfg;
    if (!playing || n < 2 || jc == 0) return;
    el  = now_ms - origin_ms;
    fin = (el >= key_time[n-1]);
    i   = 0;
    if (!fin) begin
      while (i + 1 < n && el > key_time[i+1]) i++;
    end
    if (i + 1 >= n) fin = 1'b1;
    t0 = key_time[i];
    t1 = fin ? '0 : key_time[i+1];
    for (int j = 0; j < jc; j++) begin
      r.joint = JidxW'(j);
      r.last  = (j + 1 == jc);
      if (fin) r.pos = key_pos[n-1][j];
      else if (el < t0) r.pos = key_pos[i][j];
      else if (t1 == t0) r.pos = key_pos[i+1][j];
      else r.pos = blend(key_pos[i][j], key_pos[i+1][j], el - t0, t1 - t0);
      joint_pos_q.insert(joint_pos_q.size(), r);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    joint_pos_t e;
    if (!rst_ni) begin
      joint_pos_q.delete();
      playing       = 1'b0;
      origin_ms     = '0;
      frames_cfg    = 0;
      joints_cfg    = 1;
      err_count_o   <= 0;
      pending_o     <= 0;
      joints_seen_o <= 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        if (cfg.index == CFG_FRAME_COUNT) frames_cfg = cfg.data[FcW-1:0];
        else if (cfg.index == CFG_JOINT_COUNT) joints_cfg = cfg.data[JcW-1:0];
      end
      if (req.valid && req.ready) begin
        case (req.req_type)
          REQ_LOAD: begin
            key_time[req.frame_index] = req.time_ms;
            key_pos[req.frame_index][req.joint_index] = req.position;
          end
          REQ_START: begin
            if (frames_cfg != 0) begin
              playing   = 1'b1;
              origin_ms = req.time_ms;
            end
          end
          REQ_TICK: predict_tick(req.time_ms);
          default: ;
        endcase
      end
      if (res.valid && res.ready) begin
        joints_seen_o <= joints_seen_o + 1;
        if (joint_pos_q.size() == 0) begin
          $error("unexpected result transaction: joint %0d position %h",
                 res.out_joint, res.out_position);
          err_count_o <= err_count_o + 1;
        end else begin
          e = joint_pos_q.pop_front();
          if (res.out_joint !== e.joint || res.out_position !== e.pos ||
              res.last !== e.last) begin
            err_count_o <= err_count_o + 1;
            if (res.out_joint !== e.joint)
              $error("out_joint: expected %0d, actual %0d", e.joint, res.out_joint);
            if (res.out_position !== e.pos)
              $error("out_position: expected %h, actual %h", e.pos, res.out_position);
            if (res.last !== e.last)
              $error("last: expected %0b, actual %0b", e.last, res.last);
          end
        end
      end
      pending_o <= joint_pos_q.size();
    end
  end

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kji_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  kji_req_if req_if ();
  kji_res_if res_if ();
  kji_cfg_if cfg_if ();

  int unsigned err_count;
  int unsigned pending;
  int unsigned joints_seen;

  keyframe_joint_interpolator_unit u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  kji_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req           (req_if),
    .res           (res_if),
    .cfg           (cfg_if),
    .err_count_o   (err_count),
    .pending_o     (pending),
    .joints_seen_o (joints_seen)
  );

  always #10 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("DONE: errors detected");
    $finish;
  end

  // The receiver cycles through full speed, random stalls and a fixed stall pattern.
  int unsigned cyc;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cyc <= 0;
      res_if.ready <= 1'b0;
    end else begin
      cyc <= cyc + 1;
      case (cyc[9:8])
        2'd0: res_if.ready <= 1'b1;
        2'd1: res_if.ready <= 1'($urandom_range(0, 1));
        2'd2: res_if.ready <= (cyc % 7) > 2;
        default: res_if.ready <= ($urandom_range(0, 9) != 0);
      endcase
    end
  end

  logic [TimeW-1:0] frame_ms[256];
  logic [TimeW-1:0] origin_ms;
  int unsigned      frames_now;
  int unsigned      joints_now;
  int unsigned      burst_left;
  int unsigned      items_sent;
  int unsigned      ticks_sent;
  int unsigned      settings_used;

  task automatic send_req(req_e kind, int unsigned fidx, int unsigned jidx,
                          logic [TimeW-1:0] tms, logic [PosW-1:0] pos);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if ($urandom_range(0, 15) == 0) gap = 40;
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    req_if.req_type    <= kind;
    req_if.frame_index <= FidxW'(fidx);
    req_if.joint_index <= JidxW'(jidx);
    req_if.time_ms     <= tms;
    req_if.position    <= pos;
    req_if.valid       <= 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
    if (kind == REQ_TICK) ticks_sent++;
    if (kind == REQ_START && frames_now != 0) origin_ms = tms;
  endtask

  task automatic wait_idle();
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    req_if.valid <= 1'b0;
    cfg_if.index <= idx;
    cfg_if.data  <= CfgDatW'(value);
    cfg_if.valid <= 1'b1;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    if (idx == CFG_FRAME_COUNT) frames_now = value;
    else joints_now = value;
  endtask

  function automatic logic [PosW-1:0] rand_pos();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return '0;
      default: return $urandom();
    endcase
  endfunction

  // Writes every entry that a tick may read under the given sizes.
  task automatic fill_table(int unsigned n, int unsigned jc, bit keep_times);
    logic [TimeW-1:0] t;
    t = TimeW'($urandom_range(0, 40));
    for (int f = 0; f < n; f++) begin
      if (!keep_times) begin
        if (f > 0) begin
          t = t + TimeW'(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 120));
        end
        frame_ms[f] = t;
      end
      for (int j = 0; j < jc; j++) send_req(REQ_LOAD, f, j, frame_ms[f], rand_pos());
    end
  endtask

  function automatic logic [TimeW-1:0] pick_elapsed(int unsigned n);
    int unsigned k;
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 6))
      0: return frame_ms[k];
      1: return frame_ms[k] + TimeW'(1);
      2: return frame_ms[k] - TimeW'(1);
      3: return frame_ms[n-1] + TimeW'($urandom_range(0, 500));
      4: return TimeW'($urandom());
      default: return frame_ms[k] + TimeW'($urandom_range(0, 120));
    endcase
  endfunction

  task automatic random_phase(int unsigned fc_reg, int unsigned jc_reg, int unsigned count);
    int unsigned n;
    int unsigned jc;
    int unsigned sel;
    n  = (fc_reg > 256) ? 256 : fc_reg;
    jc = (jc_reg > 32) ? 32 : jc_reg;
    write_reg(CFG_FRAME_COUNT, fc_reg);
    write_reg(CFG_JOINT_COUNT, jc_reg);
    settings_used++;
    fill_table(n, jc, 1'b0);
    send_req(REQ_START, 0, 0, TimeW'($urandom()), '0);
    for (int k = 0; k < count; k++) begin
      sel = $urandom_range(0, 19);
      if (sel < 13) begin
        send_req(REQ_TICK, $urandom(), $urandom(), origin_ms + pick_elapsed(n), $urandom());
      end else if (sel < 16) begin
        sel = $urandom_range(0, n - 1);
        if ($urandom_range(0, 1)) begin
          frame_ms[sel] = TimeW'($urandom_range(0, frame_ms[n-1] + 50));
        end
        send_req(REQ_LOAD, sel, $urandom_range(0, jc - 1), frame_ms[sel], rand_pos());
      end else if (sel < 18) begin
        send_req(REQ_START, $urandom(), $urandom(), TimeW'($urandom()), $urandom());
      end else begin
        send_req(req_e'(2'd3), $urandom(), $urandom(), TimeW'($urandom()), $urandom());
      end
    end
    wait_idle();
  endtask

  initial begin
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_LOAD;
    req_if.frame_index = '0;
    req_if.joint_index = '0;
    req_if.time_ms     = '0;
    req_if.position    = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = CFG_FRAME_COUNT;
    cfg_if.data        = '0;
    frames_now = 0;
    joints_now = 1;
    burst_left = 0;
    origin_ms  = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Nothing is playing yet, and a start with no frames is ignored.
    send_req(REQ_TICK, 0, 0, 24'd100, '0);
    send_req(REQ_START, 0, 0, 24'd5, '0);
    send_req(REQ_TICK, 0, 0, 24'd100, '0);
    send_req(req_e'(2'd3), 8'hff, 5'h1f, 24'hff_ffff, 32'hffff_ffff);
    wait_idle();

    // Clamp before the first frame, a zero-length segment, interpolation and the end.
    write_reg(CFG_FRAME_COUNT, 4);
    write_reg(CFG_JOINT_COUNT, 4);
    settings_used++;
    frame_ms[0] = 10;
    frame_ms[1] = 10;
    frame_ms[2] = 60;
    frame_ms[3] = 90;
    fill_table(4, 4, 1'b1);
    send_req(REQ_LOAD, 2, 0, frame_ms[2], 32'h8000_0000);
    send_req(REQ_LOAD, 3, 0, frame_ms[3], 32'h7fff_ffff);
    send_req(REQ_START, 0, 0, 24'hff_fff0, '0);
    foreach (frame_ms[k]) if (k < 4) send_req(REQ_TICK, 0, 0, origin_ms + frame_ms[k], '0);
    send_req(REQ_TICK, 0, 0, origin_ms + 24'd5, '0);
    send_req(REQ_TICK, 0, 0, origin_ms + 24'd35, '0);
    send_req(REQ_TICK, 0, 0, origin_ms + 24'd75, '0);
    send_req(REQ_TICK, 0, 0, origin_ms + 24'd200, '0);
    wait_idle();
    write_reg(CFG_FRAME_COUNT, 1);
    send_req(REQ_TICK, 0, 0, origin_ms + 24'd30, '0);
    write_reg(CFG_FRAME_COUNT, 4);
    write_reg(CFG_JOINT_COUNT, 0);
    send_req(REQ_TICK, 0, 0, origin_ms + 24'd30, '0);
    wait_idle();

    random_phase(2, 63, 4);
    for (int p = 0; p < 2; p++)
      random_phase($urandom_range(2, 4), $urandom_range(1, 2), 8);

    wait_idle();
    $display("Run covered %0d request transactions, %0d of them ticks, over %0d settings.",
             items_sent, ticks_sent, settings_used);
    $display("%0d joint results checked.", joints_seen);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
